/* design/dpwsd_pkg.sv */
`default_nettype none
package dpwsd_pkg;

	localparam int NumChannels = 16;
	localparam int GrpCount = (NumChannels / 2 > 8) ? 8 : NumChannels / 2;
	localparam int FifoDepth = 4;
	localparam int DivBits = 31;

	localparam logic [3:0] BoardMarker = 4'hA;

	typedef enum logic [2:0] {
		PH_BOARD,
		PH_GRP0,
		PH_GRP1,
		PH_DIV,
		PH_EVHDR,
		PH_SAMPLES,
		PH_EXTRA2,
		PH_EXTRA1
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  module_out;
		logic [3:0]  channel;
		logic [46:0] ticks;
		logic [14:0] energy;
		logic        pileup_flag;
		logic [4:0]  extras_bits;
		logic [15:0] baseline_x4;
		logic [22:0] aggregate_counter;
	} rec_t;

	typedef struct packed {
		logic        start;
		logic [30:0] dividend;
		logic [17:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       found;
		logic [2:0] idx;
	} seek_t;

	function automatic seek_t seek_grp(input logic [7:0] mask, input logic [3:0] start);
		seek_t r;
		r = '0;
		for (int g = GrpCount - 1; g >= 0; g--) begin
			if (mask[g] && (4'(g) >= start)) begin
				r.found = 1'b1;
				r.idx   = 3'(g);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/dpwsd_div.sv */
`default_nettype none
module dpwsd_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dpwsd_pkg::div_req_t req,
	output logic                    done,
	output logic [30:0]             quotient
);
	import dpwsd_pkg::*;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [30:0] quo_q;
	logic [17:0] rem_q;
	logic [17:0] div_q;
	logic [18:0] sh;
	logic        ge;
	logic [18:0] diff;

	// one quotient bit per cycle, restoring
	always_comb begin
		sh       = {rem_q, quo_q[30]};
		ge       = sh >= {1'b0, div_q};
		diff     = sh - {1'b0, div_q};
		done     = busy_q && (cnt_q == 5'(DivBits - 1));
		quotient = {quo_q[29:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quotient;
			rem_q <= ge ? diff[17:0] : sh[17:0];
		end
	end
endmodule
`default_nettype wire

/* design/dpwsd_front.sv */
`default_nettype none
module dpwsd_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire logic [31:0]         word,
	input  wire logic                last_word,
	input  wire logic [7:0]          module_id,
	output logic                     busy,
	output logic                     rec_valid,
	output dpwsd_pkg::rec_t          rec,
	output dpwsd_pkg::div_req_t      div_req,
	input  wire logic                div_done,
	input  wire logic [30:0]         div_quo
);
	import dpwsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_q, hdr_d;
	logic [7:0]  mask_q, mask_d;
	logic [2:0]  grp_q, grp_d;
	logic [17:0] spe_q, spe_d;
	logic [30:0] evl_q, evl_d;
	logic [17:0] swl_q, swl_d;
	logic [22:0] cnt_q, cnt_d;
	logic [3:0]  ch_q, ch_d;
	logic [30:0] ttl_q, ttl_d;
	logic [31:0] ext_q, ext_d;
	seek_t       nxt_grp, first_grp;
	logic [17:0] spe_w;
	logic [17:0] swl_dec;
	logic [30:0] evl_dec;

	always_comb begin
		nxt_grp   = seek_grp(mask_q, {1'b0, grp_q} + 4'd1);
		first_grp = seek_grp(mask_q, 4'd0);
		spe_w     = {word[15:0], 2'b00};
		swl_dec   = (swl_q != '0) ? swl_q - 18'd1 : swl_q;
		evl_dec   = (evl_q != '0) ? evl_q - 31'd1 : evl_q;
		busy      = (phase_q == PH_DIV);

		phase_d = phase_q;
		hdr_d   = hdr_q;
		mask_d  = mask_q;
		grp_d   = grp_q;
		spe_d   = spe_q;
		evl_d   = evl_q;
		swl_d   = swl_q;
		cnt_d   = cnt_q;
		ch_d    = ch_q;
		ttl_d   = ttl_q;
		ext_d   = ext_q;
		rec_valid = 1'b0;
		rec       = '0;
		div_req   = '0;

		case (phase_q)
			PH_BOARD: begin
				if (acc) begin
					case (hdr_q)
						2'd0: begin
							if (word[31:28] != BoardMarker) begin
								rec_valid      = 1'b1;
								rec.kind       = 1'b1;
								rec.module_out = module_id;
							end
							hdr_d = 2'd1;
						end
						2'd1: begin
							mask_d = word[7:0];
							hdr_d  = 2'd2;
						end
						2'd2: begin
							cnt_d = word[22:0];
							hdr_d = 2'd3;
						end
						default: begin
							hdr_d = 2'd0;
							if (first_grp.found) begin
								grp_d   = first_grp.idx;
								phase_d = PH_GRP0;
							end
						end
					endcase
				end
			end
			PH_GRP0: begin
				if (acc) begin
					evl_d   = word[30:0];
					phase_d = PH_GRP1;
				end
			end
			PH_GRP1: begin
				if (acc) begin
					spe_d = spe_w;
					if (evl_q >= 31'd2) begin
						div_req.start    = !last_word;
						div_req.dividend = evl_q - 31'd2;
						div_req.divisor  = spe_w + 18'd3;
						phase_d          = PH_DIV;
					end else begin
						evl_d = '0;
						if (nxt_grp.found) begin
							grp_d   = nxt_grp.idx;
							phase_d = PH_GRP0;
						end else begin
							phase_d = PH_BOARD;
							hdr_d   = 2'd0;
						end
					end
				end
			end
			PH_DIV: begin
				if (div_done) begin
					evl_d = div_quo;
					if (div_quo != '0) begin
						phase_d = PH_EVHDR;
					end else if (nxt_grp.found) begin
						grp_d   = nxt_grp.idx;
						phase_d = PH_GRP0;
					end else begin
						phase_d = PH_BOARD;
						hdr_d   = 2'd0;
					end
				end
			end
			PH_EVHDR: begin
				if (acc) begin
					ch_d    = {grp_q, word[31]};
					ttl_d   = word[30:0];
					swl_d   = spe_q;
					phase_d = (spe_q != '0) ? PH_SAMPLES : PH_EXTRA2;
				end
			end
			PH_SAMPLES: begin
				if (acc) begin
					swl_d = swl_dec;
					if (swl_dec == '0) begin
						phase_d = PH_EXTRA2;
					end
				end
			end
			PH_EXTRA2: begin
				if (acc) begin
					ext_d   = word;
					phase_d = PH_EXTRA1;
				end
			end
			PH_EXTRA1: begin
				if (acc) begin
					if (word[14:0] != '0) begin
						rec_valid             = 1'b1;
						rec.module_out        = module_id;
						rec.channel           = ch_q;
						rec.ticks             = {ext_q[31:16], ttl_q};
						rec.energy            = word[14:0];
						rec.pileup_flag       = word[15];
						rec.extras_bits       = word[20:16];
						rec.baseline_x4       = ext_q[15:0];
						rec.aggregate_counter = cnt_q;
					end
					evl_d = evl_dec;
					if (evl_dec != '0) begin
						phase_d = PH_EVHDR;
					end else if (nxt_grp.found) begin
						grp_d   = nxt_grp.idx;
						phase_d = PH_GRP0;
					end else begin
						phase_d = PH_BOARD;
						hdr_d   = 2'd0;
					end
				end
			end
			default: begin
				phase_d = PH_BOARD;
				hdr_d   = 2'd0;
			end
		endcase

		if (acc && last_word) begin
			phase_d = PH_BOARD;
			hdr_d   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BOARD;
			hdr_q   <= '0;
			mask_q  <= '0;
			grp_q   <= '0;
			spe_q   <= '0;
			evl_q   <= '0;
			swl_q   <= '0;
			cnt_q   <= '0;
			ch_q    <= '0;
			ttl_q   <= '0;
			ext_q   <= '0;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			mask_q  <= mask_d;
			grp_q   <= grp_d;
			spe_q   <= spe_d;
			evl_q   <= evl_d;
			swl_q   <= swl_d;
			cnt_q   <= cnt_d;
			ch_q    <= ch_d;
			ttl_q   <= ttl_d;
			ext_q   <= ext_d;
		end
	end
endmodule
`default_nettype wire

/* design/dpwsd_back.sv */
`default_nettype none
module dpwsd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rec_valid,
	input  wire dpwsd_pkg::rec_t rec_in,
	output logic               full,
	input  wire logic [4:0]    tick_ns,
	output logic               out_valid_q,
	output dpwsd_pkg::rec_t    out_rec_q,
	output logic [50:0]        out_ts_q,
	input  wire logic          out_pop
);
	import dpwsd_pkg::*;

	localparam int PtrW = $clog2(FifoDepth);

	rec_t            fifo_q [FifoDepth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0]   cnt_q;
	logic            take;
	logic [51:0]     prod;

	assign full = (cnt_q == (PtrW + 1)'(FifoDepth));
	assign take = (cnt_q != '0) && (!out_valid_q || out_pop);
	assign prod = {5'd0, fifo_q[rp_q].ticks} * {47'd0, tick_ns};

	// small queue between parser and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_valid) begin
				wp_q <= wp_q + PtrW'(1);
			end
			if (take) begin
				rp_q <= rp_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (PtrW + 1)'(rec_valid) - (PtrW + 1)'(take);
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid) begin
			fifo_q[wp_q] <= rec_in;
		end
		if (take) begin
			out_rec_q <= fifo_q[rp_q];
			out_ts_q  <= prod[50:0];
		end
	end
endmodule
`default_nettype wire

/* design/dpp_pha_word_stream_decoder_top.sv */
`default_nettype none
// Parser for digitizer DPP-PHA board aggregates. Words are pushed one per cycle while
// full is low; after the second group header word, full stays high while the
// iterative event-count divider runs. Results (event records and bad board markers)
// pass a four-entry queue and an output register, where the timestamp is scaled by
// tick_ns. Write tick_ns (cfg_we, cfg_wdata) only when idle.
module dpp_pha_word_stream_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] word,
	input  wire logic        last_word,
	input  wire logic [7:0]  module_id,
	input  wire logic        pop,
	output logic             empty,
	output logic             kind,
	output logic [7:0]       module_out,
	output logic [3:0]       channel,
	output logic [50:0]      timestamp_ns,
	output logic [14:0]      energy,
	output logic             pileup_flag,
	output logic [4:0]       extras_bits,
	output logic [15:0]      baseline_x4,
	output logic [22:0]      aggregate_counter
);
	import dpwsd_pkg::*;

	logic [4:0]  tick_q;
	logic        acc;
	logic        busy;
	logic        q_full;
	logic        rec_valid;
	rec_t        rec;
	div_req_t    div_req;
	logic        div_done;
	logic [30:0] div_quo;
	logic        out_valid;
	rec_t        out_rec;
	logic [50:0] out_ts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 5'd2;
		end else if (cfg_we) begin
			tick_q <= cfg_wdata;
		end
	end

	assign full  = busy || q_full;
	assign acc   = push && !full;
	assign empty = !out_valid;

	dpwsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	dpwsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.word      (word),
		.last_word (last_word),
		.module_id (module_id),
		.busy      (busy),
		.rec_valid (rec_valid),
		.rec       (rec),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_quo   (div_quo)
	);

	dpwsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (rec_valid),
		.rec_in      (rec),
		.full        (q_full),
		.tick_ns     (tick_q),
		.out_valid_q (out_valid),
		.out_rec_q   (out_rec),
		.out_ts_q    (out_ts),
		.out_pop     (pop)
	);

	assign kind              = out_rec.kind;
	assign module_out        = out_rec.module_out;
	assign channel           = out_rec.channel;
	assign timestamp_ns      = out_ts;
	assign energy            = out_rec.energy;
	assign pileup_flag       = out_rec.pileup_flag;
	assign extras_bits       = out_rec.extras_bits;
	assign baseline_x4       = out_rec.baseline_x4;
	assign aggregate_counter = out_rec.aggregate_counter;
endmodule
`default_nettype wire
